>>> src/g16h_pkg.sv
// Shared types, constants and the bin calculation for the 16-bit grey-level histogram engine.
// Used by the engine top level and the clearing sweep; it depends on nothing else.
`default_nettype none

package g16h_pkg;

  // Store geometry and field widths.
  localparam int unsigned MaxBins   = 1024;
  localparam int unsigned CountBits = 32;
  localparam int unsigned IdxW      = $clog2(MaxBins);
  localparam int unsigned PixW      = 16;
  localparam int unsigned BinsW     = 11;
  localparam int unsigned ProdW     = PixW + BinsW;

  localparam logic [BinsW-1:0] BinsReset = BinsW'(256);
  localparam logic [BinsW-1:0] BinsMax   = BinsW'(MaxBins);

  // Command codes.
  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // One command beat.
  typedef struct packed {
    cmd_e        command;
    logic [15:0] pixel_value;
    logic [9:0]  read_index;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [9:0]  bin_index;
    logic [31:0] bin_count;
    logic [31:0] max_count;
  } result_t;

  // Status and write port of the clearing sweep.
  typedef struct packed {
    logic            busy;
    logic            we;
    logic [IdxW-1:0] addr;
  } clr_t;

  // Bin of a pixel: (pixel * bins) >> 16, with the bin count clamped to 1..MaxBins.
  function automatic logic [IdxW-1:0] bin_of(input logic [PixW-1:0]  pixel,
                                             input logic [BinsW-1:0] bins_cfg);
    logic [BinsW-1:0] eff;
    logic [ProdW-1:0] prod;
    eff = bins_cfg;
    if (bins_cfg == '0) begin
      eff = BinsW'(1);
    end else if (bins_cfg > BinsMax) begin
      eff = BinsMax;
    end
    prod = ProdW'(pixel) * ProdW'(eff);
    return prod[PixW +: IdxW];
  endfunction

endpackage

`default_nettype wire

>>> src/g16h_bin_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the bin counters.
// Read data is registered; stands alone, no package needed.
`default_nettype none

module g16h_bin_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/g16h_clear_seq.sv
// Clearing sweep for the bin store: writes zero to every entry, one per cycle.
// Depends on g16h_pkg for the store depth and the status struct.
`default_nettype none

module g16h_clear_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clear_req_i,
  output g16h_pkg::clr_t     clr_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } state_e;

  localparam logic [g16h_pkg::IdxW-1:0] LastAddr = g16h_pkg::IdxW'(g16h_pkg::MaxBins - 1);

  state_e                      state_q, state_d;
  logic [g16h_pkg::IdxW-1:0]   addr_q, addr_d;

  // Next state: a sweep starts at reset and on every clear command.
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (clear_req_i) begin
          state_d = ST_SWEEP;
          addr_d  = '0;
        end
      end
      ST_SWEEP: begin
        addr_d = addr_q + g16h_pkg::IdxW'(1);
        if (addr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SWEEP;
        addr_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  assign clr_o.busy = (state_q == ST_SWEEP);
  assign clr_o.we   = (state_q == ST_SWEEP);
  assign clr_o.addr = addr_q;

endmodule

`default_nettype wire

>>> src/gray16_histogram_engine.sv
// Top level of the 16-bit grey-level histogram engine: command pipeline, counters, maximum.
// Depends on g16h_pkg, g16h_bin_ram and g16h_clear_seq.
`default_nettype none

// A command is taken at a clock edge with start high and busy low, and its single result
// appears on result_o with result_strobe_o high for one cycle, after the update and result
// registers; the receiver cannot stall it. Accumulate, read and no-operation commands can
// be issued every cycle: the bin store is read in the cycle a command is taken and written
// back in the next, and a write still in flight is forwarded to a following command on the
// same bin. A clear command, and reset, start a sweep that zeroes the 1024-entry store one
// entry per cycle; busy stays high until the last entry is written. The bin count register
// may be written at any time the engine holds no command in flight.
module gray16_histogram_engine (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire g16h_pkg::cmd_t           cmd_i,
  output g16h_pkg::result_t             result_o,
  output logic                          result_strobe_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [g16h_pkg::BinsW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = g16h_pkg::IdxW;
  localparam int unsigned CntW = g16h_pkg::CountBits;

  g16h_pkg::clr_t          clr;
  logic                    accept;
  logic [g16h_pkg::BinsW-1:0] bins_q;

  logic [IdxW-1:0]         a_idx;
  logic                    b_vld_q;
  g16h_pkg::cmd_e          b_cmd_q;
  logic [IdxW-1:0]         b_idx_q;

  logic [CntW-1:0]         ram_rdata;
  logic [CntW-1:0]         cur;
  logic [CntW-1:0]         inc;
  logic                    b_wr;

  logic                    fwd_vld_q, fwd_vld_d;
  logic [IdxW-1:0]         fwd_idx_q;
  logic [CntW-1:0]         fwd_val_q;

  logic [CntW-1:0]         max_q, max_d;
  g16h_pkg::result_t       res_q, res_d;
  logic                    res_vld_q;

  logic                    ram_we;
  logic [IdxW-1:0]         ram_waddr;
  logic [CntW-1:0]         ram_wdata;

  assign accept = start && !clr.busy;
  assign busy   = clr.busy;

  // Bin count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= g16h_pkg::BinsReset;
    end else if (cfg_we_i) begin
      bins_q <= cfg_wdata_i;
    end
  end

  // Issue stage: pick the bin to read.
  always_comb begin
    if (cmd_i.command == g16h_pkg::CMD_ACC) begin
      a_idx = g16h_pkg::bin_of(cmd_i.pixel_value, bins_q);
    end else begin
      a_idx = cmd_i.read_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_cmd_q <= cmd_i.command;
      b_idx_q <= a_idx;
    end
  end

  // Clearing sweep.
  g16h_clear_seq u_clear_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_req_i (accept && (cmd_i.command == g16h_pkg::CMD_CLEAR)),
    .clr_o       (clr)
  );

  // Bin store; the sweep and the write-back never overlap.
  assign ram_we    = clr.we || b_wr;
  assign ram_waddr = clr.we ? clr.addr : b_idx_q;
  assign ram_wdata = clr.we ? '0 : inc;

  g16h_bin_ram #(
    .Depth (g16h_pkg::MaxBins),
    .Width (CntW)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (a_idx),
    .rdata_o (ram_rdata)
  );

  // Update stage: forward the previous write-back, saturating increment.
  assign cur  = (fwd_vld_q && (fwd_idx_q == b_idx_q)) ? fwd_val_q : ram_rdata;
  assign inc  = (cur == '1) ? cur : cur + CntW'(1);
  assign b_wr = b_vld_q && (b_cmd_q == g16h_pkg::CMD_ACC);

  always_comb begin
    max_d     = max_q;
    fwd_vld_d = fwd_vld_q;
    res_d     = '0;
    if (b_vld_q) begin
      unique case (b_cmd_q)
        g16h_pkg::CMD_ACC: begin
          if (inc > max_q) begin
            max_d = inc;
          end
          fwd_vld_d       = 1'b1;
          res_d.bin_index = b_idx_q;
          res_d.bin_count = inc;
          res_d.max_count = (inc > max_q) ? inc : max_q;
        end
        g16h_pkg::CMD_READ: begin
          res_d.bin_index = b_idx_q;
          res_d.bin_count = cur;
          res_d.max_count = max_q;
        end
        g16h_pkg::CMD_CLEAR: begin
          max_d     = '0;
          fwd_vld_d = 1'b0;
        end
        g16h_pkg::CMD_NOP: begin
          res_d.max_count = max_q;
        end
        default: begin
          res_d.max_count = max_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= '0;
      fwd_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      max_q     <= max_d;
      fwd_vld_q <= fwd_vld_d;
      res_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_wr) begin
      fwd_idx_q <= b_idx_q;
      fwd_val_q <= inc;
    end
    if (b_vld_q) begin
      res_q <= res_d;
    end
  end

  assign result_o        = res_q;
  assign result_strobe_o = res_vld_q;

`ifndef SYNTHESIS
  // The sweep and the counter write-back never compete for the write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(clr.we && b_wr))
    else $error("clearing sweep and write-back collide");

  // Every accepted command gives its result strobe after the update and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> ##2 result_strobe_o)
    else $error("result missing two cycles after a command");

  // The maximum never falls below a reported bin count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (result_o.max_count >= result_o.bin_count))
    else $error("bin count above the tracked maximum");

  // A sweep always ends on the last entry of the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> ($past(clr.addr) == IdxW'(g16h_pkg::MaxBins - 1)))
    else $error("clearing sweep ended early");
`endif

endmodule

`default_nettype wire
